// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/fbo_pkg.sv =====
`default_nettype none

package fbo_pkg;

   localparam int unsigned RING_DEPTH = 2048;
   localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
   localparam int unsigned PTR_W      = ADDR_W + 1;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned OCC_W      = 12;
   localparam int unsigned CNT_W      = 32;
   localparam int unsigned RUN_W      = 16;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      logic             strobe;
      logic             accepted;
      logic             pop_sel;
      logic [OCC_W-1:0] occupancy;
      logic [CNT_W-1:0] overrun_total;
      logic [OCC_W-1:0] high_water;
      logic [RUN_W-1:0] burst_moved;
   } rsp_info_type;

   function automatic logic [OCC_W-1:0] to_occ(input logic [PTR_W-1:0] v);
      logic [PTR_W+OCC_W-1:0] w;
      w = {{OCC_W{1'b0}}, v};
      return w[OCC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/byte_fifo_with_overrun_stats.sv =====
// Channel   Handshake           Ports
// request   start, busy         req_opcode, req_push_byte, req_burst_last
// response  rsp_strobe          rsp_accepted, rsp_pop_byte, rsp_occupancy,
//                               rsp_overrun_total, rsp_high_water, rsp_burst_moved
//
// One item per cycle; busy is high only while reset is held, so start is
// taken on every edge after reset.
// The result appears the cycle after acceptance, for one cycle, matching the
// registered read of the byte store.
// Reset is synchronous and clears pointers, counters and the strobe; the
// byte store is not cleared and needs no clearing pass.
// The receiver cannot stall; results are never held.
`default_nettype none

module byte_fifo_with_overrun_stats import fbo_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_opcode,
   input  wire logic [BYTE_W-1:0] req_push_byte,
   input  wire logic              req_burst_last,
   output logic                   rsp_strobe,
   output logic                   rsp_accepted,
   output logic      [BYTE_W-1:0] rsp_pop_byte,
   output logic      [OCC_W-1:0]  rsp_occupancy,
   output logic      [CNT_W-1:0]  rsp_overrun_total,
   output logic      [OCC_W-1:0]  rsp_high_water,
   output logic      [RUN_W-1:0]  rsp_burst_moved
);

   logic              accept;
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;
   rsp_info_type      rsp_info;

   assign busy   = reset;
   assign accept = start && !busy;

   fbo_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_opcode     (req_opcode),
      .req_burst_last (req_burst_last),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .rsp_info       (rsp_info)
   );

   fbo_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (BYTE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_push_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // zero the byte unless this item popped one
   assign rsp_strobe        = rsp_info.strobe;
   assign rsp_accepted      = rsp_info.accepted;
   assign rsp_pop_byte      = rsp_info.pop_sel ? ram_rd_data : '0;
   assign rsp_occupancy     = rsp_info.occupancy;
   assign rsp_overrun_total = rsp_info.overrun_total;
   assign rsp_high_water    = rsp_info.high_water;
   assign rsp_burst_moved   = rsp_info.burst_moved;

endmodule

`default_nettype wire

// ===== hdl/fbo_ram.sv =====
`default_nettype none

module fbo_ram #(
   parameter int unsigned DEPTH = 2048,
   parameter int unsigned WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/fbo_ctrl.sv =====
`default_nettype none

module fbo_ctrl import fbo_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              req_opcode,
   input  wire logic              req_burst_last,
   output logic                   ram_wr_en,
   output logic      [ADDR_W-1:0] ram_wr_addr,
   output logic                   ram_rd_en,
   output logic      [ADDR_W-1:0] ram_rd_addr,
   output rsp_info_type           rsp_info
);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0] overrun_ff, overrun_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [RUN_W-1:0] run_next;
   logic [PTR_W-1:0] level, level_after;
   logic             full, empty, is_push, push_ok, pop_ok;

   logic             strobe_ff, strobe_in;
   rsp_info_type     info_ff, info_in;

   always_comb begin
      level       = wr_ptr_ff - rd_ptr_ff;
      full        = level[PTR_W-1];
      empty       = (level == '0);
      is_push     = (op_type'(req_opcode) == OP_PUSH);
      push_ok     = accept && is_push && !full;
      pop_ok      = accept && !is_push && !empty;
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push_ok);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop_ok);
      level_after = wr_ptr_in - rd_ptr_in;
      peak_in     = (push_ok && (level_after > peak_ff)) ? level_after : peak_ff;
      overrun_in  = overrun_ff + CNT_W'(accept && is_push && full);
      run_next    = run_ff + RUN_W'(push_ok || pop_ok);
      if (accept) begin
         run_in = req_burst_last ? '0 : run_next;
      end else begin
         run_in = run_ff;
      end
      strobe_in             = accept;
      info_in.strobe        = 1'b1;
      info_in.accepted      = push_ok || pop_ok;
      info_in.pop_sel       = pop_ok;
      info_in.occupancy     = to_occ(level_after);
      info_in.overrun_total = overrun_in;
      info_in.high_water    = to_occ(peak_in);
      info_in.burst_moved   = run_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         peak_ff    <= '0;
         overrun_ff <= '0;
         run_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         peak_ff    <= peak_in;
         overrun_ff <= overrun_in;
         run_ff     <= run_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info_in;
      end
   end

   always_comb begin
      rsp_info        = info_ff;
      rsp_info.strobe = strobe_ff;
   end

   assign ram_wr_en   = push_ok;
   assign ram_wr_addr = wr_ptr_ff[ADDR_W-1:0];
   assign ram_rd_en   = pop_ok;
   assign ram_rd_addr = rd_ptr_ff[ADDR_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/fbo_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module fbo_checker import fbo_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              req_opcode,
   input wire logic              rsp_strobe,
   input wire logic              rsp_accepted,
   input wire logic [BYTE_W-1:0] rsp_pop_byte
);

   `ASSERT_NEXT(a_strobe_follows_item, clock, reset, start && !busy, rsp_strobe)
   `ASSERT_NEXT(a_no_spurious_strobe, clock, reset, !(start && !busy), !rsp_strobe)
   `ASSERT_SAME(a_refused_zero_byte, clock, reset, rsp_strobe && !rsp_accepted, rsp_pop_byte == '0)
   `ASSERT_SAME(a_push_zero_byte, clock, reset, rsp_strobe && ($past(req_opcode) == OP_PUSH), rsp_pop_byte == '0)

endmodule

bind byte_fifo_with_overrun_stats fbo_checker u_fbo_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_opcode   (req_opcode),
   .rsp_strobe   (rsp_strobe),
   .rsp_accepted (rsp_accepted),
   .rsp_pop_byte (rsp_pop_byte)
);

`default_nettype wire
